// ----- rtl/core/bdpe_pkg.sv -----
package bdpe_pkg;

  // Number of buttons and the width of the raw level word on the input channel.
  localparam int NUM_BUTTONS = 4;
  localparam int RAW_W       = 4;

  // The event ring has this many slots and keeps at most one fewer events.
  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);

  localparam int MODE_W  = 2;
  localparam int TIME_W  = 32;
  localparam int BTN_W   = 2;
  localparam int ACT_W   = 2;
  localparam int REG_W   = 16;
  localparam int CIDX_W  = 8;

  // Input item operations.
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INIT = 2'd2;

  // Event actions.
  localparam logic [ACT_W-1:0] ACT_SHORT  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LONG   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REPEAT = 2'd2;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_DEBOUNCE = 8'd0;
  localparam logic [CIDX_W-1:0] REG_LONG     = 8'd1;
  localparam logic [CIDX_W-1:0] REG_RPT_STRT = 8'd2;
  localparam logic [CIDX_W-1:0] REG_RPT_INTV = 8'd3;

  // Configuration reset values in milliseconds.
  localparam logic [REG_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [REG_W-1:0] LONG_RST     = 16'd1000;
  localparam logic [REG_W-1:0] RPT_STRT_RST = 16'd1000;
  localparam logic [REG_W-1:0] RPT_INTV_RST = 16'd200;

  typedef struct packed {
    logic [BTN_W-1:0] button;
    logic [ACT_W-1:0] action;
  } evt_t;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + PTR_W'(1);
    end
    return n;
  endfunction

endpackage

// ----- rtl/core/bdpe_ifs.sv -----
interface bdpe_in_if import bdpe_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [TIME_W-1:0] now_time;
  logic [RAW_W-1:0]  raw_levels;

  modport source (output valid, mode, now_time, raw_levels, input ready);
  modport sink (input valid, mode, now_time, raw_levels, output ready);
endinterface

interface bdpe_out_if import bdpe_pkg::*;;
  logic             valid;
  logic             ready;
  logic             event_valid;
  logic [BTN_W-1:0] button_index;
  logic [ACT_W-1:0] action;

  modport source (output valid, event_valid, button_index, action, input ready);
  modport sink (input valid, event_valid, button_index, action, output ready);
endinterface

interface bdpe_cfg_if import bdpe_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [REG_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/button_debounce_press_events.sv -----
// Button debouncer with short-press, long-press and auto-repeat events. Each
// transfer on the input channel is a sample tick (mode 0, carrying a wrapping
// millisecond time and the raw button levels), a pop (mode 1) or an
// initialisation from the current levels (mode 2); mode 3 is ignored. Only a
// pop produces a transfer on the output channel: the oldest queued event, or
// all fields zero when the queue is empty. Events from one tick are queued in
// button index order into an eight-slot ring that holds up to seven events,
// and an event that finds the ring full is dropped. An item is registered on
// acceptance and handled from that register; a pop's result then goes to the
// output register. One item is accepted every cycle while the output side
// takes results; a pop waits only while the single output register is full.
// The always-ready configuration channel writes the four timing registers;
// users write them only while the block is idle; it does not enforce this.
module button_debounce_press_events import bdpe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bdpe_in_if.sink     in_i,
  bdpe_out_if.source  out_o,
  bdpe_cfg_if.sink    cfg_i
);

  // Configuration registers.
  logic [REG_W-1:0] debounce_q, long_q, rpt_strt_q, rpt_intv_q;

  // Input register.
  logic              in_vld_q;
  logic [MODE_W-1:0] mode_q;
  logic [TIME_W-1:0] now_q;
  logic [RAW_W-1:0]  lvl_q;

  // Per-button state.
  logic [NUM_BUTTONS-1:0] raw_q, raw_d;
  logic [NUM_BUTTONS-1:0] stab_q, stab_d;
  logic [NUM_BUTTONS-1:0] lrep_q, lrep_d;
  logic [TIME_W-1:0]      rc_q [NUM_BUTTONS];
  logic [TIME_W-1:0]      rc_d [NUM_BUTTONS];
  logic [TIME_W-1:0]      ps_q [NUM_BUTTONS];
  logic [TIME_W-1:0]      ps_d [NUM_BUTTONS];
  logic [TIME_W-1:0]      rs_q [NUM_BUTTONS];
  logic [TIME_W-1:0]      rs_d [NUM_BUTTONS];

  // Event ring.
  evt_t             ring_q [QUEUE_DEPTH];
  evt_t             ring_d [QUEUE_DEPTH];
  logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d;

  // Output register.
  logic             out_vld_q;
  logic             ev_vld_q;
  evt_t             ev_q;

  logic is_pop, advance, ring_empty;

  assign cfg_i.ready = 1'b1;

  assign is_pop     = (mode_q == MODE_POP);
  assign ring_empty = (head_q == tail_q);
  // The item in the input register retires unless it is a pop that finds the
  // output register full and not being taken.
  assign advance    = in_vld_q && (!is_pop || !out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  assign out_o.valid        = out_vld_q;
  assign out_o.event_valid  = ev_vld_q;
  assign out_o.button_index = ev_q.button;
  assign out_o.action       = ev_q.action;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RST;
      long_q     <= LONG_RST;
      rpt_strt_q <= RPT_STRT_RST;
      rpt_intv_q <= RPT_INTV_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_DEBOUNCE: debounce_q <= cfg_i.data;
        REG_LONG:     long_q     <= cfg_i.data;
        REG_RPT_STRT: rpt_strt_q <= cfg_i.data;
        REG_RPT_INTV: rpt_intv_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      mode_q <= in_i.mode;
      now_q  <= in_i.now_time;
      lvl_q  <= in_i.raw_levels;
    end
  end

  // Next state of the buttons and the ring. During a tick each button is
  // handled in index order, and each one's push sees the head that the
  // buttons before it left, so the full check matches sequential pushes.
  always_comb begin
    logic             raw;
    logic [TIME_W-1:0] held;
    logic             push;
    evt_t             pevt;
    logic [PTR_W-1:0] hd;

    raw_d  = raw_q;
    stab_d = stab_q;
    lrep_d = lrep_q;
    rc_d   = rc_q;
    ps_d   = ps_q;
    rs_d   = rs_q;
    ring_d = ring_q;
    tail_d = tail_q;
    hd     = head_q;

    if (advance) begin
      case (mode_q)
        MODE_TICK: begin
          for (int i = 0; i < NUM_BUTTONS; i++) begin
            raw  = lvl_q[i];
            push = 1'b0;
            pevt = '{button: BTN_W'(i), action: ACT_SHORT};
            if (raw != raw_q[i]) begin
              raw_d[i] = raw;
              rc_d[i]  = now_q;
            end
            if (((now_q - rc_d[i]) >= TIME_W'(debounce_q)) && (raw != stab_q[i])) begin
              stab_d[i] = raw;
              if (raw) begin
                ps_d[i]   = now_q;
                rs_d[i]   = now_q;
                lrep_d[i] = 1'b0;
              end else begin
                push      = !lrep_q[i];
                lrep_d[i] = 1'b0;
              end
            end
            held = now_q - ps_d[i];
            if (stab_d[i]) begin
              if (!lrep_d[i] && (held >= TIME_W'(long_q))) begin
                lrep_d[i]   = 1'b1;
                rs_d[i]     = now_q;
                push        = 1'b1;
                pevt.action = ACT_LONG;
              end else if (lrep_d[i] && (held >= TIME_W'(rpt_strt_q)) &&
                           ((now_q - rs_d[i]) >= TIME_W'(rpt_intv_q))) begin
                rs_d[i]     = now_q;
                push        = 1'b1;
                pevt.action = ACT_REPEAT;
              end
            end
            if (push && (next_ptr(hd) != tail_q)) begin
              ring_d[hd] = pevt;
              hd         = next_ptr(hd);
            end
          end
        end
        MODE_POP: begin
          if (!ring_empty) begin
            tail_d = next_ptr(tail_q);
          end
        end
        MODE_INIT: begin
          for (int i = 0; i < NUM_BUTTONS; i++) begin
            raw_d[i]  = lvl_q[i];
            stab_d[i] = lvl_q[i];
            rc_d[i]   = now_q;
            ps_d[i]   = lvl_q[i] ? now_q : '0;
          end
        end
        default: ;
      endcase
    end
    head_d = hd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q  <= '0;
      stab_q <= '0;
      lrep_q <= '0;
      head_q <= '0;
      tail_q <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        rc_q[i] <= '0;
        ps_q[i] <= '0;
        rs_q[i] <= '0;
      end
    end else begin
      raw_q  <= raw_d;
      stab_q <= stab_d;
      lrep_q <= lrep_d;
      head_q <= head_d;
      tail_q <= tail_d;
      rc_q   <= rc_d;
      ps_q   <= ps_d;
      rs_q   <= rs_d;
    end
  end

  // Ring slots are only ever read after being written, so they need no reset.
  always_ff @(posedge clk_i) begin
    ring_q <= ring_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && is_pop) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_pop) begin
      ev_vld_q <= !ring_empty;
      ev_q     <= ring_empty ? '0 : ring_q[tail_q];
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
module tb;
  import bdpe_pkg::*;

  // Mode 3 carries no operation and the block must ignore it completely.
  localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

  // A run that sees no transfer on any channel for this many cycles has hung.
  localparam int WATCHDOG_LIMIT = 4000;
  // Cycles allowed after the last result for a tick to finish inside the block.
  localparam int SETTLE_CYCLES  = 6;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TIME_W-1:0] now_time;
    logic [RAW_W-1:0]  raw_levels;
  } btn_item_t;

  typedef struct packed {
    logic event_valid;
    evt_t evt;
  } pop_result_t;

  logic clk_i;
  logic rst_ni;

  bdpe_in_if  in_if ();
  bdpe_out_if out_if ();
  bdpe_cfg_if cfg_if ();

  button_debounce_press_events dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Stimulus side: items waiting to be offered, and the idling mix of the phase.
  btn_item_t         pending_items[$];
  btn_item_t         drive_item;
  int                src_idle_pct;
  int                snk_stall_pct;
  logic              in_taken;
  int                cfg_writes;
  logic [TIME_W-1:0] stim_ms;
  logic [RAW_W-1:0]  stim_hold;

  // Our own picture of the debouncer: timing registers, per-button state,
  // the event ring (kept as a queue of at most QUEUE_DEPTH-1 events) and the
  // pop results that are still owed by the block.
  logic [TIME_W-1:0] dbnc_ms;
  logic [TIME_W-1:0] long_ms;
  logic [TIME_W-1:0] rpt_start_ms;
  logic [TIME_W-1:0] rpt_gap_ms;
  logic              btn_raw    [NUM_BUTTONS];
  logic              btn_stable [NUM_BUTTONS];
  logic              long_done  [NUM_BUTTONS];
  logic [TIME_W-1:0] raw_stamp  [NUM_BUTTONS];
  logic [TIME_W-1:0] press_at   [NUM_BUTTONS];
  logic [TIME_W-1:0] repeat_at  [NUM_BUTTONS];
  evt_t              event_ring_q[$];
  pop_result_t       due_results[$];

  int mismatches;
  int quiet_cycles;

  // The clock runs with a period of two time units from the very start.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // An event that finds the ring holding QUEUE_DEPTH-1 entries is lost.
  task automatic queue_event(input int btn, input logic [ACT_W-1:0] act);
    evt_t e;
    e.button = BTN_W'(btn);
    e.action = act;
    if (event_ring_q.size() < QUEUE_DEPTH - 1) begin
      event_ring_q.push_back(e);
    end
  endtask

  // One button on one sample tick: debounce, then short, long and repeat.
  task automatic tick_button(input int i, input logic lv, input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] since_repeat;
    if (lv != btn_raw[i]) begin
      btn_raw[i]   = lv;
      raw_stamp[i] = now;
    end
    since_change = now - raw_stamp[i];
    if (since_change >= dbnc_ms && lv != btn_stable[i]) begin
      btn_stable[i] = lv;
      if (lv) begin
        press_at[i]  = now;
        repeat_at[i] = now;
        long_done[i] = 1'b0;
      end else begin
        // A release after a long press has already been reported is silent.
        if (!long_done[i]) queue_event(i, ACT_SHORT);
        long_done[i] = 1'b0;
      end
    end
    if (btn_stable[i]) begin
      held         = now - press_at[i];
      since_repeat = now - repeat_at[i];
      if (!long_done[i] && held >= long_ms) begin
        long_done[i] = 1'b1;
        repeat_at[i] = now;
        queue_event(i, ACT_LONG);
      end else if (long_done[i] && held >= rpt_start_ms && since_repeat >= rpt_gap_ms) begin
        repeat_at[i] = now;
        queue_event(i, ACT_REPEAT);
      end
    end
  endtask

  // Advances the predicted state by one accepted item; a pop owes one result.
  task automatic track_buttons(input btn_item_t it);
    pop_result_t res;
    case (it.mode)
      MODE_TICK: begin
        for (int i = 0; i < NUM_BUTTONS; i++) tick_button(i, it.raw_levels[i], it.now_time);
      end
      MODE_POP: begin
        res = '0;
        if (event_ring_q.size() != 0) begin
          res.event_valid = 1'b1;
          res.evt         = event_ring_q.pop_front();
        end
        due_results.push_back(res);
      end
      MODE_INIT: begin
        // Long-press flags, repeat stamps and the ring survive initialisation.
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          btn_raw[i]    = it.raw_levels[i];
          btn_stable[i] = it.raw_levels[i];
          raw_stamp[i]  = it.now_time;
          press_at[i]   = it.raw_levels[i] ? it.now_time : '0;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_pop(input pop_result_t got);
    pop_result_t want;
    if (due_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("unexpected pop result: valid %0d button %0d action %0d",
                 got.event_valid, got.evt.button, got.evt.action);
      end
    end else begin
      want = due_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("pop result wrong: expected valid %0d button %0d action %0d, got %0d %0d %0d",
                   want.event_valid, want.evt.button, want.evt.action,
                   got.event_valid, got.evt.button, got.evt.action);
        end
      end
    end
  endtask

  // Monitor. Everything is sampled at the rising edge, where the inputs have
  // been steady since the falling edge and the block's outputs still hold the
  // values of the cycle that is ending. Input transfers are predicted before
  // output transfers are checked, and register writes go into the same
  // picture of the block at the edge where they take effect.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_taken     <= 1'b0;
      quiet_cycles <= 0;
      dbnc_ms      = TIME_W'(DEBOUNCE_RST);
      long_ms      = TIME_W'(LONG_RST);
      rpt_start_ms = TIME_W'(RPT_STRT_RST);
      rpt_gap_ms   = TIME_W'(RPT_INTV_RST);
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        btn_raw[i]    = 1'b0;
        btn_stable[i] = 1'b0;
        long_done[i]  = 1'b0;
        raw_stamp[i]  = '0;
        press_at[i]   = '0;
        repeat_at[i]  = '0;
      end
      event_ring_q.delete();
    end else begin
      in_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        track_buttons('{mode: in_if.mode, now_time: in_if.now_time,
                        raw_levels: in_if.raw_levels});
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_DEBOUNCE: dbnc_ms      = TIME_W'(cfg_if.data);
          REG_LONG:     long_ms      = TIME_W'(cfg_if.data);
          REG_RPT_STRT: rpt_start_ms = TIME_W'(cfg_if.data);
          REG_RPT_INTV: rpt_gap_ms   = TIME_W'(cfg_if.data);
          default: begin
          end
        endcase
        cfg_writes++;
      end
      if (out_if.valid && out_if.ready) begin
        check_pop('{event_valid: out_if.event_valid,
                    evt: '{button: out_if.button_index, action: out_if.action}});
      end
      // Watchdog: a long stretch without a single transfer means a hang.
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Driver. On each falling edge the receiver side decides whether to stall,
  // and the sender offers the next pending item once the previous one has
  // completed its transfer, or idles according to the phase's mix. A valid
  // that stays high is simply left alone, so it is never assigned twice in
  // one step.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      if (!in_if.valid || in_taken) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          drive_item = pending_items.pop_front();
          in_if.valid      <= 1'b1;
          in_if.mode       <= drive_item.mode;
          in_if.now_time   <= drive_item.now_time;
          in_if.raw_levels <= drive_item.raw_levels;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic add_item(input logic [MODE_W-1:0] mode, input logic [TIME_W-1:0] now,
                          input logic [RAW_W-1:0] lv);
    pending_items.push_back('{mode: mode, now_time: now, raw_levels: lv});
  endtask

  // The sender holds back until every owed result has been taken and the
  // block has had time to finish its last tick.
  task automatic settle();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_if.valid || due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [REG_W-1:0] val);
    int target;
    target = cfg_writes + 1;
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    do @(negedge clk_i);
    while (cfg_writes != target);
    cfg_if.valid = 1'b0;
  endtask

  // Random traffic. Each button follows a held level that flips now and then,
  // so most presses are clean holds that reach long press and repeat; a few
  // ticks carry bounce noise, and the time stamp occasionally jumps anywhere.
  task automatic queue_random(input int n, input int step_max, input int toggle_pct);
    int done;
    int r;
    logic [RAW_W-1:0] noise;
    done = 0;
    while (done < n) begin
      r = $urandom_range(99);
      if (r < 60) begin
        for (int b = 0; b < RAW_W; b++) begin
          if ($urandom_range(99) < toggle_pct) stim_hold[b] = ~stim_hold[b];
        end
        stim_ms = stim_ms + TIME_W'($urandom_range(step_max));
        if ($urandom_range(99) == 0) stim_ms = $urandom;
        noise = ($urandom_range(99) < 6) ? RAW_W'($urandom) : '0;
        add_item(MODE_TICK, stim_ms, stim_hold ^ noise);
        done++;
      end else if (r < 91) begin
        add_item(MODE_POP, $urandom, RAW_W'($urandom));
        done++;
      end else if (r < 97) begin
        add_item(MODE_INIT, stim_ms, ($urandom_range(1) != 0) ? stim_hold : RAW_W'($urandom));
        done++;
      end else begin
        // Ignored items do not count towards the phase length.
        add_item(MODE_IGNORED, $urandom, RAW_W'($urandom));
      end
    end
  endtask

  task automatic run_phase(input logic [REG_W-1:0] dbnc, input logic [REG_W-1:0] lng,
                           input logic [REG_W-1:0] rstart, input logic [REG_W-1:0] rgap,
                           input int src_pct, input int snk_pct, input int n,
                           input int step_max, input int toggle_pct);
    settle();
    write_reg(REG_DEBOUNCE, dbnc);
    write_reg(REG_LONG, lng);
    write_reg(REG_RPT_STRT, rstart);
    write_reg(REG_RPT_INTV, rgap);
    @(posedge clk_i);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    queue_random(n, step_max, toggle_pct);
  endtask

  initial begin
    logic [TIME_W-1:0] t0;
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.mode        = MODE_TICK;
    in_if.now_time    = '0;
    in_if.raw_levels  = '0;
    out_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = REG_DEBOUNCE;
    cfg_if.data       = '0;
    src_idle_pct      = 0;
    snk_stall_pct     = 0;
    cfg_writes        = 0;
    mismatches        = 0;
    stim_hold         = '0;
    t0                = 32'hFFFF_FF00;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with the reset timing (50, 1000, 1000, 200 ms) and a
    // time base that wraps through zero part of the way along. It covers a
    // pop on an empty ring, an ignored mode, initialisation, a short press
    // on button 1, a long press with one repeat on button 0 and a silent
    // release after it, then all four buttons held from initialisation so
    // that long presses and repeats overflow the ring and one is dropped.
    @(posedge clk_i);
    add_item(MODE_POP,     t0, '0);
    add_item(MODE_IGNORED, t0, 4'hF);
    add_item(MODE_INIT,    t0, 4'h0);
    add_item(MODE_TICK,    t0 + 32'd10,   4'h1);
    add_item(MODE_TICK,    t0 + 32'd60,   4'h1);
    add_item(MODE_TICK,    t0 + 32'd100,  4'h3);
    add_item(MODE_TICK,    t0 + 32'd160,  4'h3);
    add_item(MODE_TICK,    t0 + 32'd200,  4'h1);
    add_item(MODE_TICK,    t0 + 32'd260,  4'h1);
    add_item(MODE_TICK,    t0 + 32'd1060, 4'h1);
    add_item(MODE_TICK,    t0 + 32'd1260, 4'h1);
    add_item(MODE_TICK,    t0 + 32'd1310, 4'h0);
    add_item(MODE_TICK,    t0 + 32'd1400, 4'h0);
    for (int k = 0; k < 3; k++) add_item(MODE_POP, t0, '0);
    add_item(MODE_INIT,    t0 + 32'd1500, 4'hF);
    add_item(MODE_TICK,    t0 + 32'd2500, 4'hF);
    add_item(MODE_TICK,    t0 + 32'd2700, 4'hF);
    for (int k = 0; k < 7; k++) add_item(MODE_POP, t0, '0);
    stim_ms   = t0 + 32'd3000;
    stim_hold = 4'hF;

    // Random phases. Each begins only once everything owed has arrived, which
    // also gives the sender its pause on an empty pipeline, and each moves the
    // time step in proportion to the timing registers it sets.
    run_phase(DEBOUNCE_RST, LONG_RST, RPT_STRT_RST, RPT_INTV_RST, 66, 0, 100, 150, 8);
    run_phase(16'd0, 16'd0, 16'd0, 16'd0, 0, 66, 80, 3, 10);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7, 7, 70, 30000, 4);
    run_phase(16'd3, 16'd20, 16'd30, 16'd5, 0, 0, 120, 6, 6);
    run_phase(16'd10, 16'd100, 16'd300, 16'd0, 66, 0, 90, 25, 5);
    run_phase(REG_W'($urandom_range(40)), REG_W'($urandom_range(300)),
              REG_W'($urandom_range(400)), REG_W'($urandom_range(60)), 0, 66, 80, 20, 6);
    run_phase(REG_W'($urandom), REG_W'($urandom), REG_W'($urandom), REG_W'($urandom),
              7, 7, 60, 25000, 4);
    settle();

    if (mismatches == 0 && due_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
